### rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared widths and byte-classification constants of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 2;

  // Top-bit masks and markers of the lead byte forms.
  localparam logic [ByteW-1:0] ContMarker = 8'h80;
  localparam logic [ByteW-1:0] Mask2      = 8'hE0;
  localparam logic [ByteW-1:0] Lead2      = 8'hC0;
  localparam logic [ByteW-1:0] Mask3      = 8'hF0;
  localparam logic [ByteW-1:0] Lead3      = 8'hE0;
  localparam logic [ByteW-1:0] Mask4      = 8'hF8;
  localparam logic [ByteW-1:0] Lead4      = 8'hF0;

  localparam logic [CountW-1:0] Follow1 = 2'd1;
  localparam logic [CountW-1:0] Follow2 = 2'd2;
  localparam logic [CountW-1:0] Follow3 = 2'd3;

endpackage

### rtl/utf8_to_code_point_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_core
// Decodes a UTF-8 byte stream into code points, one byte per beat.
// ----------------------------------------------------------------------------
// Path: a completing byte goes via the input register to the result register.
// Throughput: one byte per cycle while no result waits on a stalled output,
// set by the combinational update of the pending count and accumulator between
// the input and result registers. Reset: asynchronous, active low; clears both
// stages and the decode state, so no sequence is open after reset.
module utf8_to_code_point_decoder_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [utf8d_pkg::ByteW-1:0]  data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [utf8d_pkg::CpW-1:0]    code_point_o,
  output logic                         bad_lead_o
);

  // Input register.
  logic                         s1_valid_q;
  logic [utf8d_pkg::ByteW-1:0]  s1_byte_q;

  // Decode state.
  logic [utf8d_pkg::CountW-1:0] pend_q, pend_d;
  logic [utf8d_pkg::CpW-1:0]    acc_q, acc_d;

  // Result register.
  logic                         out_valid_q;
  logic [utf8d_pkg::CpW-1:0]    cp_q, cp_d;
  logic                         bad_q, bad_d;

  logic emit;
  logic s1_fire;
  logic [utf8d_pkg::CpW-1:0] acc_shift;

  assign acc_shift = {acc_q[utf8d_pkg::CpW-7:0], 6'd0}
                   | {13'd0, s1_byte_q ^ utf8d_pkg::ContMarker};

  always_comb begin
    pend_d = pend_q;
    acc_d  = acc_q;
    emit   = 1'b0;
    cp_d   = '0;
    bad_d  = 1'b0;
    if (pend_q != '0) begin
      // Any byte inside an open sequence is taken as a following byte.
      pend_d = pend_q - 2'd1;
      if (pend_q == utf8d_pkg::Follow1) begin
        emit  = 1'b1;
        cp_d  = acc_shift;
        acc_d = '0;
      end else begin
        acc_d = acc_shift;
      end
    end else if (!s1_byte_q[7]) begin
      emit = 1'b1;
      cp_d = {13'd0, s1_byte_q};
    end else if ((s1_byte_q & utf8d_pkg::Mask2) == utf8d_pkg::Lead2) begin
      acc_d  = {13'd0, s1_byte_q ^ utf8d_pkg::Lead2};
      pend_d = utf8d_pkg::Follow1;
    end else if ((s1_byte_q & utf8d_pkg::Mask3) == utf8d_pkg::Lead3) begin
      acc_d  = {13'd0, s1_byte_q ^ utf8d_pkg::Lead3};
      pend_d = utf8d_pkg::Follow2;
    end else if ((s1_byte_q & utf8d_pkg::Mask4) == utf8d_pkg::Lead4) begin
      acc_d  = {13'd0, s1_byte_q ^ utf8d_pkg::Lead4};
      pend_d = utf8d_pkg::Follow3;
    end else begin
      emit  = 1'b1;
      bad_d = 1'b1;
    end
  end

  // A byte that yields no result never waits on the output side.
  assign s1_fire    = s1_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pend_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        pend_q <= pend_d;
        acc_q  <= acc_d;
      end
      if (s1_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= data_byte_i;
    end
    if (s1_fire && emit) begin
      cp_q  <= cp_d;
      bad_q <= bad_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign bad_lead_o   = bad_q;

endmodule

### rtl/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks of the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [utf8d_pkg::CpW-1:0]    code_point_o,
  input logic                         bad_lead_o
);

  // An error result carries no code point.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_lead_o |-> code_point_o == '0)
    else $error("bad_lead result with nonzero code point");

  // A fresh result comes from a beat that went through the input register and then the result register.
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without a matching input beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before the beat");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(code_point_o) && $stable(bad_lead_o))
    else $error("stalled result changed");

endmodule

bind utf8_to_code_point_decoder_core utf8d_checker u_utf8d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .code_point_o (code_point_o),
  .bad_lead_o   (bad_lead_o)
);

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 decoder core. A byte-level decode
// predictor runs on every accepted input beat and queues the code point it
// expects. Results are compared in order, field by field. The run covers
// directed lead and follow bytes, then random streams that are mostly
// well-formed and partly noise, under several idle and stall mixes. One
// test holds the result side off for a long stretch so that the core fills.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ResultLatency = 2;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainLimit    = 5000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned PhaseBytes    = 150;

  typedef logic [utf8d_pkg::ByteW-1:0] byte_t;
  typedef logic [utf8d_pkg::CpW-1:0]   cp_word_t;

  // Payload bits of a follow byte.
  localparam byte_t FollowMask = 8'h3F;

  typedef struct packed {
    cp_word_t code_point;
    logic     bad_lead;
  } cp_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  byte_t               data_byte_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  cp_word_t            code_point_o;
  logic                bad_lead_o;

  // Decode state of the predictor.
  logic [utf8d_pkg::CountW-1:0] exp_pending = '0;
  cp_word_t            exp_acc     = '0;
  cp_result_t          expected_cp_q[$];

  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_off_left     = 0;
  int unsigned idle_cycles       = 0;
  int unsigned beats_in          = 0;
  int unsigned results_seen      = 0;
  int unsigned mismatch_count    = 0;
  int unsigned phases_run        = 0;

  utf8_to_code_point_decoder_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_point_o (code_point_o),
    .bad_lead_o   (bad_lead_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  // Advances the predicted decode state by one byte and queues the code point
  // when a sequence completes, a 1-byte form arrives or the lead is bad.
  function automatic void decode_expected(input byte_t value);
    if (exp_pending != '0) begin
      // Follow bytes are not checked, so all eight bits go in.
      exp_acc     = (exp_acc << 6) | cp_word_t'(value ^ utf8d_pkg::ContMarker);
      exp_pending = exp_pending - 1'b1;
      if (exp_pending == '0) begin
        expected_cp_q.push_back('{code_point: exp_acc, bad_lead: 1'b0});
        exp_acc = '0;
      end
    end else if ((value & utf8d_pkg::ContMarker) == '0) begin
      expected_cp_q.push_back('{code_point: cp_word_t'(value), bad_lead: 1'b0});
    end else if ((value & utf8d_pkg::Mask2) == utf8d_pkg::Lead2) begin
      exp_acc     = cp_word_t'(value ^ utf8d_pkg::Lead2);
      exp_pending = utf8d_pkg::Follow1;
    end else if ((value & utf8d_pkg::Mask3) == utf8d_pkg::Lead3) begin
      exp_acc     = cp_word_t'(value ^ utf8d_pkg::Lead3);
      exp_pending = utf8d_pkg::Follow2;
    end else if ((value & utf8d_pkg::Mask4) == utf8d_pkg::Lead4) begin
      exp_acc     = cp_word_t'(value ^ utf8d_pkg::Lead4);
      exp_pending = utf8d_pkg::Follow3;
    end else begin
      expected_cp_q.push_back('{code_point: '0, bad_lead: 1'b1});
    end
  endfunction

  // Checks result beats, predicts on input beats and counts quiet cycles.
  always @(posedge clk_i) begin : beat_monitor
    cp_result_t want;
    logic       progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        progress = 1'b1;
        results_seen++;
        if (expected_cp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result code_point %06h bad_lead %0b",
                                    code_point_o, bad_lead_o));
        end else begin
          want = expected_cp_q.pop_front();
          if (code_point_o !== want.code_point) begin
            report_mismatch($sformatf("code_point expected %06h got %06h",
                                      want.code_point, code_point_o));
          end
          if (bad_lead_o !== want.bad_lead) begin
            report_mismatch($sformatf("bad_lead expected %0b got %0b",
                                      want.bad_lead, bad_lead_o));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        progress = 1'b1;
        beats_in++;
        decode_expected(data_byte_i);
      end
    end
    idle_cycles = progress ? 0 : idle_cycles + 1;
  end

  // Result side: random stalls, or a forced hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_ready_i   <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= receiver_stall_pct);
    end
  end

  initial begin : watchdog
    while (idle_cycles < WatchdogLimit) @(negedge clk_i);
    $display("watchdog: no beat for %0d cycles", WatchdogLimit);
    $display("TB_ERROR");
    $finish;
  end

  // Offers one byte, with random gaps before it, and waits for its beat.
  task automatic send_byte(input byte_t value);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Mostly well-formed sequences with random payloads; the rest is random
  // noise and sequences cut short by one follow byte.
  task automatic send_random_stream(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned seq_len;
    int unsigned followers;
    byte_t       payload;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(99, 0) < 20) begin
        send_byte(byte_t'($urandom));
        sent++;
      end else begin
        seq_len = $urandom_range(4, 1);
        payload = byte_t'($urandom);
        case (seq_len)
          1: send_byte(payload & ~utf8d_pkg::ContMarker);
          2: send_byte(utf8d_pkg::Lead2 | (payload & ~utf8d_pkg::Mask2));
          3: send_byte(utf8d_pkg::Lead3 | (payload & ~utf8d_pkg::Mask3));
          default: send_byte(utf8d_pkg::Lead4 | (payload & ~utf8d_pkg::Mask4));
        endcase
        sent++;
        followers = seq_len - 1;
        if (followers > 0 && $urandom_range(9, 0) == 0) begin
          followers--;
        end
        repeat (followers) begin
          send_byte(utf8d_pkg::ContMarker | (byte_t'($urandom) & FollowMask));
          sent++;
        end
      end
    end
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    sender_idle_pct    = send_pct;
    receiver_stall_pct = recv_pct;
    phases_run++;
  endtask

  task automatic test_directed_bytes();
    byte_t bytes[$];
    set_idling(0, 0);
    // Zero byte, top 1-byte lead, stray follow bytes and 11111xxx leads.
    bytes = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF};
    // Two-, three- and four-byte sequences, the widest code point included.
    bytes = {bytes, 8'hC2, 8'hA9, 8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC};
    bytes = {bytes, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
    // Overlong form of U+0000.
    bytes = {bytes, 8'hC0, 8'h80};
    // Malformed follow bytes, a zero byte among them, are folded in unchecked.
    bytes = {bytes, 8'hE1, 8'h00, 8'hFF};
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  task automatic test_no_idling();
    set_idling(0, 0);
    send_random_stream(PhaseBytes);
  endtask

  task automatic test_sender_gaps();
    set_idling(74, 0);
    send_random_stream(PhaseBytes);
  endtask

  task automatic test_receiver_stalls();
    set_idling(0, 74);
    send_random_stream(PhaseBytes);
  endtask

  task automatic test_both_idle();
    set_idling(7, 7);
    send_random_stream(PhaseBytes);
  endtask

  // The result side holds off while bytes keep coming, so the core fills
  // up and drops its input ready.
  task automatic test_output_hold_off();
    set_idling(0, 0);
    send_byte(8'h41);
    hold_off_left = HoldOffCycles;
    send_random_stream(60);
  endtask

  task automatic drain_and_report();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    receiver_stall_pct = 0;
    for (int unsigned i = 0; i < DrainLimit && expected_cp_q.size() != 0; i++) begin
      @(posedge clk_i);
    end
    repeat (ResultLatency + 8) @(posedge clk_i);
    if (expected_cp_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_cp_q.size()));
    end
    $display("Decoded %0d input bytes over %0d tests, including a %0d-cycle output hold-off.",
             beats_in, phases_run, HoldOffCycles);
    $display("Compared %0d results; %0d mismatches.", results_seen, mismatch_count);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_bytes();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_output_hold_off();
    drain_and_report();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
